>>> sv/tridiagonal_system_solver_core_macros.svh
// ----------------------------------------------------------------------------
// tridiagonal solver assertion macros
// clocked, reset-qualified implication checks shared by the rtl
// ----------------------------------------------------------------------------
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_CORE_MACROS_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_CORE_MACROS_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tss_pkg.sv
// ----------------------------------------------------------------------------
// tridiagonal solver package
// word types, status codes, controller states and fixed-point helpers
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int ADDR_W    = $clog2(MAX_ROWS);
	localparam int CNT_W     = $clog2(MAX_ROWS + 1);
	localparam int IDX_W     = 6;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int DIV_BITS  = WORD_W + FRAC_W;
	localparam int DIV_RADIX = 2;
	localparam int DIV_CYC   = DIV_BITS / DIV_RADIX;
	localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_PIVOT = 2'd1,
		ST_SIZE  = 2'd2
	} status_t;

	typedef struct packed {
		word_t csup;
		word_t drhs;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_F_CHK, S_F_RD, S_F_M1, S_F_M2, S_F_PIV, S_F_DIV, S_F_END,
		S_B_INIT, S_B_LD, S_B_RD, S_B_MUL, S_B_WR, S_O_RD, S_O_LD, S_O_HOLD
	} state_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// q16.16 product: round to nearest, ties away from zero, saturate
	function automatic word_t rnd_q(input prod_t p);
		logic             neg;
		logic [PROD_W-1:0] m;
		begin
			neg = p[PROD_W-1];
			m   = neg ? PROD_W'(-p) : PROD_W'(p);
			m   = (m + (PROD_W'(1) << (FRAC_W - 1))) >> FRAC_W;
			if (!neg)
				rnd_q = (m > PROD_W'(WORD_MAX)) ? WORD_MAX : word_t'(m[WORD_W-1:0]);
			else
				rnd_q = (m > PROD_W'({1'b1, {(WORD_W-1){1'b0}}})) ? WORD_MIN
					: word_t'(-m[WORD_W-1:0]);
		end
	endfunction

	// saturating difference
	function automatic word_t sub_sat(input word_t a, input word_t b);
		logic signed [WORD_W:0] s;
		begin
			s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
			if (s[WORD_W] != s[WORD_W-1])
				sub_sat = s[WORD_W] ? WORD_MIN : WORD_MAX;
			else
				sub_sat = word_t'(s[WORD_W-1:0]);
		end
	endfunction

endpackage

>>> sv/tss_ram.sv
// ----------------------------------------------------------------------------
// tss single-port ram
// one access per cycle, registered read data
// ----------------------------------------------------------------------------
module tss_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we)
				mem[addr] <= wdata;
			else
				rdata <= mem[addr];
		end
	end

endmodule

>>> sv/tss_div.sv
// ----------------------------------------------------------------------------
// tss fixed-point divider
// (|n| << 16) / |d| rounded to nearest, then signed and saturated, two quotient bits per cycle
// ----------------------------------------------------------------------------
module tss_div import tss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  word_t num,
	input  word_t den,
	output logic  done,
	output word_t quot
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [WORD_W-1:0]    den_q;
	logic [DIV_BITS-1:0]  dvd_q;
	logic [WORD_W:0]      rem_q;
	logic [DIV_BITS-1:0]  quo_q;

	logic [WORD_W-1:0]    num_mag;
	logic [WORD_W-1:0]    den_mag;
	logic [WORD_W:0]      rem_n;
	logic [DIV_BITS-1:0]  dvd_n;
	logic [DIV_BITS-1:0]  quo_n;

	assign num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
	assign den_mag = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);

	// restoring steps
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		quo_n = quo_q;
		for (int k = 0; k < DIV_RADIX; k++) begin
			rem_n = {rem_n[WORD_W-1:0], dvd_n[DIV_BITS-1]};
			dvd_n = {dvd_n[DIV_BITS-2:0], 1'b0};
			if (rem_n >= {1'b0, den_q}) begin
				rem_n = rem_n - {1'b0, den_q};
				quo_n = {quo_n[DIV_BITS-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_CYC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
			den_q <= den_mag;
			dvd_q <= {num_mag, {FRAC_W{1'b0}}} + {{(DIV_BITS-WORD_W+1){1'b0}}, den_mag[WORD_W-1:1]};
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	// sign and saturation
	always_comb begin
		if (!neg_q)
			quot = (quo_q > DIV_BITS'(WORD_MAX)) ? WORD_MAX : word_t'(quo_q[WORD_W-1:0]);
		else
			quot = (quo_q > DIV_BITS'({1'b1, {(WORD_W-1){1'b0}}})) ? WORD_MIN
				: word_t'(-quo_q[WORD_W-1:0]);
	end

	assign done = done_q;

endmodule

>>> sv/tridiagonal_system_solver_core.sv
// ----------------------------------------------------------------------------
// tridiagonal system solver core
// thomas algorithm on signed q16.16 rows held in one single-port ram
// ----------------------------------------------------------------------------
// per row after the first: ram read of c'[r-1], d'[r-1], two shared-multiplier
// passes, both dividers on the pivot, then write-back; back substitution
// reads, multiplies and writes each row; output reads each word and holds it
// until the sink is ready; one row accepted at a time
// reset: async active low clears the controller, row count and error status;
// ram contents are not cleared and never read before being written
`include "tridiagonal_system_solver_core_macros.svh"

module tridiagonal_system_solver_core import tss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // sub_diag, main_diag, super_diag, rhs
	input  logic         s_tlast,   // row_last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // solution, row_index, zero pad
	output logic         m_tlast,   // result_last
	output logic [1:0]   m_tuser    // status
);

	state_t state_q, state_d;

	// row registers
	word_t a_q, b_q, c_q, d_q;
	logic  last_q;

	// system state
	logic [CNT_W-1:0]  row_cnt_q;
	status_t           err_q;
	logic [ADDR_W-1:0] idx_q;

	// datapath
	word_t piv_q, num_q, x_q;
	prod_t prod_q;
	word_t mul_a, mul_b;
	word_t x_new;

	// output word register
	logic             out_valid_q;
	word_t            out_data_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_last_q;
	status_t          out_stat_q;

	// ram port
	logic              ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	entry_t            ram_wdata, ram_rdata;
	logic [$bits(entry_t)-1:0] ram_rd_raw;

	// dividers share the pivot
	logic  div_start, divc_done, divd_done;
	word_t divc_q, divd_q;

	logic size_bad;

	tss_ram #(.DEPTH(MAX_ROWS), .WIDTH($bits(entry_t))) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rd_raw)
	);
	assign ram_rdata = entry_t'(ram_rd_raw);

	tss_div u_divc (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(c_q), .den(piv_q), .done(divc_done), .quot(divc_q)
	);

	tss_div u_divd (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_q), .den(piv_q), .done(divd_done), .quot(divd_q)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_idx_q, out_data_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_stat_q;

	// fewer than two rows, or a row dropped for lack of room
	assign size_bad = (err_q == ST_SIZE) || (row_cnt_q < CNT_W'(2));

	// back substitution step: x[i] = d'[i] - c'[i] * x[i+1]
	assign x_new = sub_sat(ram_rdata.drhs, rnd_q(prod_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state, ram and unit control
	always_comb begin
		state_d   = state_q;
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = idx_q;
		ram_wdata = '{csup: ram_rdata.csup, drhs: x_new};
		div_start = 1'b0;
		mul_a     = a_q;
		mul_b     = ram_rdata.csup;
		unique case (state_q)
			S_IDLE:
				if (s_tvalid) state_d = S_F_CHK;
			S_F_CHK: begin
				if (row_cnt_q >= CNT_W'(MAX_ROWS)) begin
					state_d = S_F_END;
				end else if (row_cnt_q == '0) begin
					state_d = S_F_PIV;
				end else begin
					// fetch c'[r-1], d'[r-1]
					ram_en   = 1'b1;
					ram_addr = ADDR_W'(row_cnt_q - 1'b1);
					state_d  = S_F_RD;
				end
			end
			S_F_RD:
				state_d = S_F_M1;        // a * c'[r-1]
			S_F_M1: begin
				mul_b   = ram_rdata.drhs; // a * d'[r-1]
				state_d = S_F_M2;
			end
			S_F_M2:
				state_d = S_F_PIV;
			S_F_PIV: begin
				if (piv_q == '0) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = ADDR_W'(row_cnt_q);
					ram_wdata = '{csup: '0, drhs: '0};
					state_d   = S_F_END;
				end else begin
					div_start = 1'b1;
					state_d   = S_F_DIV;
				end
			end
			S_F_DIV: begin
				if (divc_done) begin
					ram_en    = 1'b1;
					ram_we    = 1'b1;
					ram_addr  = ADDR_W'(row_cnt_q);
					ram_wdata = '{csup: last_q ? word_t'(0) : divc_q, drhs: divd_q};
					state_d   = S_F_END;
				end
			end
			S_F_END: begin
				if (!last_q)
					state_d = S_IDLE;
				else if (size_bad)
					state_d = S_O_HOLD;
				else
					state_d = S_B_INIT;
			end
			S_B_INIT: begin
				ram_en   = 1'b1;
				ram_addr = ADDR_W'(row_cnt_q - 1'b1);
				state_d  = S_B_LD;
			end
			S_B_LD:
				state_d = S_B_RD;
			S_B_RD: begin
				ram_en  = 1'b1;
				state_d = S_B_MUL;
			end
			S_B_MUL: begin
				mul_a   = ram_rdata.csup;
				mul_b   = x_q;
				state_d = S_B_WR;
			end
			S_B_WR: begin
				// x overwrites d' in place, c' kept
				ram_en  = 1'b1;
				ram_we  = 1'b1;
				state_d = (idx_q == '0) ? S_O_RD : S_B_RD;
			end
			S_O_RD: begin
				ram_en  = 1'b1;
				state_d = S_O_LD;
			end
			S_O_LD:
				state_d = S_O_HOLD;
			S_O_HOLD: begin
				if (m_tready)
					state_d = out_last_q ? S_IDLE : S_O_RD;
			end
			default:
				state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cnt_q   <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_F_CHK:
					if (row_cnt_q >= CNT_W'(MAX_ROWS)) err_q <= ST_SIZE;
				S_F_PIV:
					if (piv_q == '0) begin
						row_cnt_q <= row_cnt_q + 1'b1;
						if (err_q == ST_OK) err_q <= ST_PIVOT;
					end
				S_F_DIV:
					if (divc_done) row_cnt_q <= row_cnt_q + 1'b1;
				S_F_END:
					if (last_q && size_bad) out_valid_q <= 1'b1;
				S_O_LD:
					out_valid_q <= 1'b1;
				S_O_HOLD:
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							row_cnt_q <= '0;
							err_q     <= ST_OK;
						end
					end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= prod_t'(mul_a) * prod_t'(mul_b);
		unique case (state_q)
			S_IDLE:
				if (s_tvalid) begin
					a_q    <= word_t'(s_tdata[31:0]);
					b_q    <= word_t'(s_tdata[63:32]);
					c_q    <= word_t'(s_tdata[95:64]);
					d_q    <= word_t'(s_tdata[127:96]);
					last_q <= s_tlast;
				end
			S_F_CHK:
				if (row_cnt_q == '0) begin
					piv_q <= b_q;
					num_q <= d_q;
				end
			S_F_M1:
				piv_q <= sub_sat(b_q, rnd_q(prod_q));
			S_F_M2:
				num_q <= sub_sat(d_q, rnd_q(prod_q));
			S_F_END: begin
				// size error word
				out_data_q <= '0;
				out_idx_q  <= '0;
				out_last_q <= 1'b1;
				out_stat_q <= ST_SIZE;
			end
			S_B_LD: begin
				x_q   <= ram_rdata.drhs;
				idx_q <= ADDR_W'(row_cnt_q - CNT_W'(2));
			end
			S_B_WR: begin
				x_q <= x_new;
				if (idx_q != '0) idx_q <= idx_q - 1'b1;
			end
			S_O_LD: begin
				out_data_q <= ram_rdata.drhs;
				out_idx_q  <= IDX_W'(idx_q);
				out_last_q <= (CNT_W'(idx_q) == row_cnt_q - 1'b1);
				out_stat_q <= err_q;
			end
			S_O_HOLD:
				if (m_tready && !out_last_q) idx_q <= idx_q + 1'b1;
			default: ;
		endcase
	end

	`TSS_ASSERT_NOW(a_div_done_state, divc_done, state_q == S_F_DIV && divd_done,
		"divider finished outside the divide step")
	`TSS_ASSERT_NEXT(a_clear_after_last, m_tvalid && m_tready && m_tlast,
		row_cnt_q == '0 && err_q == ST_OK && s_tready,
		"system state not cleared after final word")
	`TSS_ASSERT_NOW(a_no_size_mid, m_tvalid && !m_tlast, m_tuser != ST_SIZE,
		"size error word not marked last")
	`TSS_ASSERT_NOW(a_cnt_bound, s_tready, row_cnt_q <= CNT_W'(MAX_ROWS),
		"row count beyond storage")

endmodule
